FILE: rtl/postfix_integer_evaluator_macros.svh
// assertion macros for the postfix integer evaluator
`ifndef POSTFIX_INTEGER_EVALUATOR_MACROS_SVH
`define POSTFIX_INTEGER_EVALUATOR_MACROS_SVH

// same-cycle implication
`define PIE_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("postfix evaluator check failed");

// next-cycle implication
`define PIE_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("postfix evaluator check failed");

`endif

FILE: rtl/pie_pkg.sv
// shared constants, types and codes of the postfix integer evaluator
`timescale 1ns / 1ps

package pie_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_APPLY  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [3:0] OPC_ADD = 4'd0;
    localparam logic [3:0] OPC_SUB = 4'd1;
    localparam logic [3:0] OPC_MUL = 4'd2;
    localparam logic [3:0] OPC_DIV = 4'd3;
    localparam logic [3:0] OPC_MOD = 4'd4;
    localparam logic [3:0] OPC_OR  = 4'd5;
    localparam logic [3:0] OPC_AND = 4'd6;
    localparam logic [3:0] OPC_EQ  = 4'd7;
    localparam logic [3:0] OPC_NE  = 4'd8;
    localparam logic [3:0] OPC_LT  = 4'd9;
    localparam logic [3:0] OPC_GT  = 4'd10;
    localparam logic [3:0] OPC_LE  = 4'd11;
    localparam logic [3:0] OPC_GE  = 4'd12;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_DIV_ZERO  = 3'd1,
        STS_UNDERFLOW = 3'd2,
        STS_OVERFLOW  = 3'd3,
        STS_BAD_OP    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_OPER,
        KIND_FINISH,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         code;
        logic [DATA_W-1:0]  operand;
    } t_cmd;

    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [DATA_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic [DATA_W-1:0]  quotient;
        logic [DATA_W-1:0]  remainder;
    } t_div_rsp;

endpackage

FILE: rtl/pie_front.sv
// token intake: classifies each token and queues it for the execution side
`timescale 1ns / 1ps

module pie_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_op,
    input  logic [3:0]                 i_operator_code,
    input  logic signed [31:0]         i_operand_value,
    output logic                       o_cmd_valid,
    output pie_pkg::t_cmd              o_cmd,
    input  logic                       i_cmd_pop
);
    import pie_pkg::*;

    t_cmd               r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_fill;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_fill;
    logic               w_push;
    logic               w_pop;
    t_cmd               w_new;

    always_comb begin
        w_new.code    = i_operator_code;
        w_new.operand = i_operand_value;
        case (i_op)
            OP_PUSH:   w_new.kind = KIND_PUSH;
            OP_APPLY:  w_new.kind = (i_operator_code > OPC_GE) ? KIND_BAD : KIND_OPER;
            OP_FINISH: w_new.kind = KIND_FINISH;
            default:   w_new.kind = KIND_BAD;
        endcase
    end

    assign o_in_stall  = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_new;
        end
    end

endmodule

FILE: rtl/pie_div.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pie_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pie_pkg::t_div_req   i_req,
    output pie_pkg::t_div_rsp   o_rsp
);
    import pie_pkg::*;

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DATA_W-1:0]      r_quo;
    logic [DATA_W-1:0]      r_rem;
    logic [DATA_W-1:0]      r_dvs;
    logic [DATA_W:0]        w_shift;
    logic [DATA_W:0]        w_diff;

    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
            r_rem <= w_diff[DATA_W] ? w_shift[DATA_W-1:0] : w_diff[DATA_W-1:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: rtl/pie_back.sv
// execution side: operand stack, operator sequencing and result register
`timescale 1ns / 1ps

module pie_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  pie_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    output pie_pkg::t_div_req   o_div_req,
    input  pie_pkg::t_div_rsp   i_div_rsp,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_value,
    output logic [2:0]          o_status,
    output logic                o_not_boolean,
    output logic                o_is_final
);
    import pie_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    function automatic logic [DATA_W-1:0] alu(input logic [3:0] code,
                                              input logic [DATA_W-1:0] l,
                                              input logic [DATA_W-1:0] r);
        logic [DATA_W-1:0] res;
        res = '0;
        case (code)
            OPC_ADD: res = l + r;
            OPC_SUB: res = l - r;
            OPC_MUL: res = l * r;
            OPC_OR:  res = DATA_W'((l != '0) || (r != '0));
            OPC_AND: res = DATA_W'((l != '0) && (r != '0));
            OPC_EQ:  res = DATA_W'(l == r);
            OPC_NE:  res = DATA_W'(l != r);
            OPC_LT:  res = DATA_W'($signed(l) < $signed(r));
            OPC_GT:  res = DATA_W'($signed(l) > $signed(r));
            OPC_LE:  res = DATA_W'($signed(l) <= $signed(r));
            OPC_GE:  res = DATA_W'($signed(l) >= $signed(r));
            default: res = '0;
        endcase
        return res;
    endfunction

    logic [DATA_W-1:0]  r_stack [STACK_DEPTH];
    logic [DATA_W-1:0]  r_top;
    logic [DATA_W-1:0]  r_sec;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [3:0]         r_code;
    logic               r_is_fin;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_value;
    t_status            r_status;
    logic               r_not_bool;
    logic               r_is_final;

    t_state             n_state;
    logic [CNT_W-1:0]   n_count;
    logic [3:0]         n_code;
    logic               n_is_fin;
    logic               n_out_valid;
    logic [DATA_W-1:0]  n_value;
    t_status            n_status;
    logic               n_not_bool;
    logic               n_is_final;

    logic               w_out_free;
    logic               w_mem_we;
    logic [PTR_W-1:0]   w_mem_waddr;
    logic [DATA_W-1:0]  w_mem_wdata;
    logic               w_mem_re;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic [CNT_W-1:0]   w_cnt_m2;
    logic               w_is_divmod;
    logic [DATA_W-1:0]  w_div_res;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cnt_m1    = r_count - 1'b1;
    assign w_cnt_m2    = r_count - CNT_W'(2);
    assign w_is_divmod = (r_code == OPC_DIV) || (r_code == OPC_MOD);

    // sign fix-up of the magnitude result
    always_comb begin
        if (r_code == OPC_DIV) begin
            w_div_res = (r_sec[DATA_W-1] ^ r_top[DATA_W-1]) ? (DATA_W'(0) - i_div_rsp.quotient)
                                                            : i_div_rsp.quotient;
        end else begin
            w_div_res = r_sec[DATA_W-1] ? (DATA_W'(0) - i_div_rsp.remainder)
                                        : i_div_rsp.remainder;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_code      = r_code;
        n_is_fin    = r_is_fin;
        n_out_valid = r_out_valid && i_out_stall;
        n_value     = r_value;
        n_status    = r_status;
        n_not_bool  = r_not_bool;
        n_is_final  = r_is_final;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_cnt_m2[PTR_W-1:0];
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        o_cmd_pop   = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_sec[DATA_W-1] ? (DATA_W'(0) - r_sec) : r_sec;
        o_div_req.divisor  = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop  = 1'b1;
                    n_value    = '0;
                    n_not_bool = 1'b0;
                    n_is_final = 1'b0;
                    case (i_cmd.kind)
                        KIND_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_count >= CNT_W'(STACK_DEPTH)) begin
                                n_status = STS_OVERFLOW;
                            end else begin
                                n_status    = STS_OK;
                                w_mem_we    = 1'b1;
                                w_mem_waddr = r_count[PTR_W-1:0];
                                w_mem_wdata = i_cmd.operand;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        KIND_OPER: begin
                            if (r_count < CNT_W'(2)) begin
                                n_out_valid = 1'b1;
                                n_status    = STS_UNDERFLOW;
                            end else begin
                                w_mem_re = 1'b1;
                                n_code   = i_cmd.code;
                                n_is_fin = 1'b0;
                                n_state  = S_EXEC;
                            end
                        end
                        KIND_FINISH: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STS_UNDERFLOW;
                                n_is_final  = 1'b1;
                            end else begin
                                w_mem_re = 1'b1;
                                n_is_fin = 1'b1;
                                n_state  = S_EXEC;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = STS_BAD_OP;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (r_is_fin) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_value     = r_top;
                        n_status    = STS_OK;
                        n_not_bool  = (r_top > DATA_W'(1));
                        n_is_final  = 1'b1;
                        n_count     = '0;
                        n_state     = S_IDLE;
                    end
                end else if (w_is_divmod && (r_top != '0)) begin
                    o_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_not_bool  = 1'b0;
                    n_is_final  = 1'b0;
                    n_state     = S_IDLE;
                    if (w_is_divmod) begin
                        n_value  = '0;
                        n_status = STS_DIV_ZERO;
                    end else begin
                        n_value     = alu(r_code, r_sec, r_top);
                        n_status    = STS_OK;
                        w_mem_we    = 1'b1;
                        w_mem_wdata = n_value;
                        n_count     = w_cnt_m1;
                    end
                end
            end
            S_DIV: begin
                if (!i_div_rsp.busy && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_value     = w_div_res;
                    n_status    = STS_OK;
                    n_not_bool  = 1'b0;
                    n_is_final  = 1'b0;
                    w_mem_we    = 1'b1;
                    w_mem_wdata = w_div_res;
                    n_count     = w_cnt_m1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_code      <= '0;
            r_is_fin    <= 1'b0;
            r_value     <= '0;
            r_status    <= STS_OK;
            r_not_bool  <= 1'b0;
            r_is_final  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
            r_is_fin    <= n_is_fin;
            r_value     <= n_value;
            r_status    <= n_status;
            r_not_bool  <= n_not_bool;
            r_is_final  <= n_is_final;
        end
    end

    // operand stack, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_stack[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_top <= r_stack[w_cnt_m1[PTR_W-1:0]];
            r_sec <= r_stack[w_cnt_m2[PTR_W-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_status      = r_status;
    assign o_not_boolean = r_not_bool;
    assign o_is_final    = r_is_final;

endmodule

FILE: rtl/postfix_integer_evaluator.sv
// postfix integer evaluator: push, error and empty-finish tokens are answered straight from the idle state;
// finish, non-dividing operators and a zero divisor first read the stack into the execute state
// one push or error token a cycle while the output is not stalled; divide and modulo also wait for
// the one-bit-per-cycle divider (32 steps); 2-entry token queue
// synchronous active-low reset clears the queue, stack count, state and result valid
// operand stack contents are not cleared by reset
`timescale 1ns / 1ps
`include "postfix_integer_evaluator_macros.svh"

module postfix_integer_evaluator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [3:0]          i_operator_code,
    input  logic signed [31:0]  i_operand_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_value,
    output logic [2:0]          o_status,
    output logic                o_not_boolean,
    output logic                o_is_final
);
    import pie_pkg::*;

    logic       w_cmd_valid;
    logic       w_cmd_pop;
    t_cmd       w_cmd;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;

    pie_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_operator_code (i_operator_code),
        .i_operand_value (i_operand_value),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    pie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    pie_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_not_boolean (o_not_boolean),
        .o_is_final    (o_is_final)
    );

    `PIE_ASSERT_IMP(a_err_value_zero, i_clk, i_rst_n, o_out_valid && (o_status != STS_OK), o_value == 32'sd0)
    `PIE_ASSERT_IMP(a_not_bool_final, i_clk, i_rst_n, o_out_valid && o_not_boolean, o_is_final && (o_status == STS_OK))
    `PIE_ASSERT_IMP(a_no_pop_in_div, i_clk, i_rst_n, w_div_rsp.busy, !w_cmd_pop)
    `PIE_ASSERT_NXT(a_div_start_busy, i_clk, i_rst_n, w_div_req.start, w_div_rsp.busy)

endmodule
